### rtl/poisson_jacobi_sweep_7pt_assert.svh
// Assertion macros for the checker of the Jacobi sweep block.
`ifndef POISSON_JACOBI_SWEEP_7PT_ASSERT_SVH
`define POISSON_JACOBI_SWEEP_7PT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define PJS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pjs assertion failed");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PJS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pjs assertion failed");

// Consequent must hold in the cycle after the antecedent, checked through reset.
`define PJS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pjs assertion failed");

`endif

### rtl/pjs_pkg.sv
// Package of types, constants and helper functions for the Jacobi sweep block.
package pjs_pkg;

  localparam int PJS_MAX_X = 64;
  localparam int PJS_MAX_Y = 64;
  localparam int PJS_MAX_Z = 64;

  localparam int WORD_W      = 32;
  localparam int POS_W       = 6;
  localparam int PEAK_W      = 31;
  localparam int CMPW        = 11;
  localparam int PROD_W      = 34;
  localparam int CFG_AW      = 5;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_W      = $clog2(FIFO_DEPTH);
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;
  localparam int VAL_LSB     = 3 * POS_W;
  localparam int PEAK_LSB    = VAL_LSB + WORD_W;
  localparam logic [35:0] ONE_Q30 = 36'd1 << 30;

  typedef enum logic [2:0] {
    REG_COEF_X,
    REG_COEF_Y,
    REG_COEF_Z,
    REG_COEF_RHO,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_EDGE_MASK
  } pjs_reg_t;

  // Side information that travels with an item down the arithmetic pipeline.
  typedef struct packed {
    logic                     odd;
    logic                     interior;
    logic                     has_first;
    logic                     first_copy;
    logic                     has_second;
    logic                     second_copy;
    logic                     last;
    logic                     clear;
    logic [POS_W-1:0]         px;
    logic [POS_W-1:0]         qx;
    logic [POS_W-1:0]         py;
    logic [POS_W-1:0]         pz;
    logic signed [WORD_W-1:0] pot;
    logic signed [WORD_W-1:0] centre;
  } ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0]         px;
    logic [POS_W-1:0]         py;
    logic [POS_W-1:0]         pz;
    logic signed [WORD_W-1:0] value;
    logic                     written;
    logic [PEAK_W-1:0]        peak;
    logic                     last;
  } res_t;

  function automatic logic [CMPW-1:0] eff_size(input logic [6:0] s, input int unsigned mx);
    logic [CMPW-1:0] r;
    if (s < 7'd3) r = CMPW'(3);
    else if (32'(s) > mx) r = CMPW'(mx);
    else r = CMPW'(s);
    return r;
  endfunction

  function automatic logic on_face(input logic [5:0] mask,
                                   input logic [CMPW-1:0] px, py, pz, sx, sy, sz);
    return (mask[0] && px == '0) || (mask[1] && px + CMPW'(1) == sx) ||
           (mask[2] && py == '0) || (mask[3] && py + CMPW'(1) == sy) ||
           (mask[4] && pz == '0) || (mask[5] && pz + CMPW'(1) == sz);
  endfunction

  // Product of a Q16.16 value and a Q2.30 weight, floored to Q18.16.
  function automatic logic signed [PROD_W-1:0] mul_floor(input logic signed [31:0] a,
                                                          input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:30];
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [36:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 37'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -37'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

endpackage

### rtl/pjs_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
module pjs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [W-1:0]             rdata0,
  output logic [W-1:0]             rdata1
);

  logic [W-1:0] mem [DEPTH];

  // Reads return the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/poisson_jacobi_sweep_7pt.sv
// Top level of the weighted Jacobi sweep over a 7-point Poisson stencil.
//
//  Channel   Direction  Handshake                 Payload
//  in_*      input      in_tvalid / in_tready     tdata: potential, density
//  out_*     output     out_tvalid / out_tready   tdata: position, value, peak;
//                                                 tuser: written; tlast: last
//  cfg       input      psel/penable/pwrite       paddr, pwdata, prdata
//
// Throughput is one item per cycle while the result queue has room; in the last x
// plane each item yields two results and the single result port then sets the
// pace. Once its item is accepted, a result passes these steps to the output:
// the plane reads are taken at the acceptance edge, then the multiplies, the pair
// sums, the total, the change, and the peak update and queue write.
// Reset is synchronous; the plane memories need no clearing pass, so items are
// accepted from the first cycle after reset. A stalled output only halts input
// once fewer than two of the sixteen queue slots are free of results and
// reservations.
//
// Each item reads its neighbourhood from the previous x plane, the old value at
// the same place in the current plane and the density, all in the cycle it is
// accepted, and writes its own potential and density in that same cycle. As the
// memories return the old data on a same-address write, and the next item reads
// only at its own acceptance, no forwarding is needed. The potential planes are
// held three times over so that the five neighbour reads fit on dual-read RAMs.
module poisson_jacobi_sweep_7pt import pjs_pkg::*; #(
  parameter int MAX_X = PJS_MAX_X,
  parameter int MAX_Y = PJS_MAX_Y,
  parameter int MAX_Z = PJS_MAX_Z
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: potential [31:0], density [63:32]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: pos_x [5:0], pos_y [11:6], pos_z [17:12], new_potential [49:18],
  // max_change [80:50], zero fill [87:81]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: written
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int ZW    = $clog2(MAX_Z);
  localparam int DEPTH = MAX_Y * MAX_Z;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [30:0]        coef_x_r, coef_y_r, coef_z_r;
  logic signed [31:0] coef_rho_r;
  logic [6:0]         size_x_r, size_y_r, size_z_r;
  logic [5:0]         edge_mask_r;
  logic               cfg_wr;
  pjs_reg_t           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = pjs_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r    <= '0;
      coef_y_r    <= '0;
      coef_z_r    <= '0;
      coef_rho_r  <= '0;
      size_x_r    <= 7'd64;
      size_y_r    <= 7'd64;
      size_z_r    <= 7'd64;
      edge_mask_r <= 6'h3F;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COEF_X:    coef_x_r    <= pwdata[30:0];
        REG_COEF_Y:    coef_y_r    <= pwdata[30:0];
        REG_COEF_Z:    coef_z_r    <= pwdata[30:0];
        REG_COEF_RHO:  coef_rho_r  <= $signed(pwdata);
        REG_SIZE_X:    size_x_r    <= pwdata[6:0];
        REG_SIZE_Y:    size_y_r    <= pwdata[6:0];
        REG_SIZE_Z:    size_z_r    <= pwdata[6:0];
        REG_EDGE_MASK: edge_mask_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_X:    prdata = {1'b0, coef_x_r};
      REG_COEF_Y:    prdata = {1'b0, coef_y_r};
      REG_COEF_Z:    prdata = {1'b0, coef_z_r};
      REG_COEF_RHO:  prdata = coef_rho_r;
      REG_SIZE_X:    prdata = {25'd0, size_x_r};
      REG_SIZE_Y:    prdata = {25'd0, size_y_r};
      REG_SIZE_Z:    prdata = {25'd0, size_z_r};
      REG_EDGE_MASK: prdata = {26'd0, edge_mask_r};
      default:       prdata = '0;
    endcase
  end

  // Raster position and decisions taken at acceptance.
  logic [XW-1:0] count_x_r, count_x_nxt;
  logic [YW-1:0] count_y_r, count_y_nxt;
  logic [ZW-1:0] count_z_r, count_z_nxt;
  logic [CMPW-1:0] sx, sy, sz, xc, yc, zc, pxc, zn, yn, xn;
  logic          in_acc;
  logic signed [WORD_W-1:0] in_pot, in_den;
  logic [AW-1:0] idx;
  logic [AW-1:0] rd_addr [3][2];
  ctrl_t         c0;

  assign in_acc = in_tvalid && in_tready;
  assign in_pot = $signed(in_tdata[WORD_W-1:0]);
  assign in_den = $signed(in_tdata[2*WORD_W-1:WORD_W]);

  always_comb begin
    sx  = eff_size(size_x_r, MAX_X);
    sy  = eff_size(size_y_r, MAX_Y);
    sz  = eff_size(size_z_r, MAX_Z);
    xc  = CMPW'(count_x_r);
    yc  = CMPW'(count_y_r);
    zc  = CMPW'(count_z_r);
    pxc = xc - CMPW'(1);
    idx = AW'(AW'(count_y_r) * AW'(MAX_Z)) + AW'(count_z_r);

    rd_addr[0][0] = idx;
    rd_addr[0][1] = idx - AW'(MAX_Z);
    rd_addr[1][0] = idx + AW'(MAX_Z);
    rd_addr[1][1] = idx - AW'(1);
    rd_addr[2][0] = idx + AW'(1);
    rd_addr[2][1] = idx;

    c0.odd         = count_x_r[0];
    c0.has_first   = (count_x_r != '0);
    c0.interior    = c0.has_first && (pxc >= CMPW'(1)) && (pxc + CMPW'(2) <= sx) &&
                     (yc >= CMPW'(1)) && (yc + CMPW'(2) <= sy) &&
                     (zc >= CMPW'(1)) && (zc + CMPW'(2) <= sz);
    c0.first_copy  = on_face(edge_mask_r, pxc, yc, zc, sx, sy, sz);
    c0.has_second  = (xc + CMPW'(1) >= sx);
    c0.second_copy = on_face(edge_mask_r, xc, yc, zc, sx, sy, sz);
    c0.last        = (yc + CMPW'(1) >= sy) && (zc + CMPW'(1) >= sz);
    c0.clear       = (count_x_r == '0) && (count_y_r == '0) && (count_z_r == '0);
    c0.px          = POS_W'(pxc);
    c0.qx          = POS_W'(count_x_r);
    c0.py          = POS_W'(count_y_r);
    c0.pz          = POS_W'(count_z_r);
    c0.pot         = in_pot;
    c0.centre      = '0;

    // Step z, then y, then x; a counter left past a smaller size wraps here.
    zn = zc + CMPW'(1);
    yn = yc;
    xn = xc;
    if (zn >= sz) begin
      zn = '0;
      yn = yc + CMPW'(1);
      if (yn >= sy) begin
        yn = '0;
        xn = xc + CMPW'(1);
        if (xn >= sx) begin
          xn = '0;
        end
      end
    end
    count_x_nxt = XW'(xn);
    count_y_nxt = YW'(yn);
    count_z_nxt = ZW'(zn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_x_r <= '0;
      count_y_r <= '0;
      count_z_r <= '0;
    end else if (in_acc) begin
      count_x_r <= count_x_nxt;
      count_y_r <= count_y_nxt;
      count_z_r <= count_z_nxt;
    end
  end

  // Plane memories: three copies of each potential plane and one density plane.
  logic [WORD_W-1:0] a_rd [3][2];
  logic [WORD_W-1:0] b_rd [3][2];
  logic [WORD_W-1:0] d_rd0, d_rd1;

  for (genvar g = 0; g < 3; g++) begin : g_copy
    pjs_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_plane_a (
      .clk    (clk),
      .we     (in_acc && !count_x_r[0]),
      .waddr  (idx),
      .wdata  (in_pot),
      .raddr0 (rd_addr[g][0]),
      .raddr1 (rd_addr[g][1]),
      .rdata0 (a_rd[g][0]),
      .rdata1 (a_rd[g][1])
    );
    pjs_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_plane_b (
      .clk    (clk),
      .we     (in_acc && count_x_r[0]),
      .waddr  (idx),
      .wdata  (in_pot),
      .raddr0 (rd_addr[g][0]),
      .raddr1 (rd_addr[g][1]),
      .rdata0 (b_rd[g][0]),
      .rdata1 (b_rd[g][1])
    );
  end

  // Both density ports read the same entry; the second carries no extra use.
  pjs_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_density (
    .clk    (clk),
    .we     (in_acc),
    .waddr  (idx),
    .wdata  (in_den),
    .raddr0 (idx),
    .raddr1 (idx),
    .rdata0 (d_rd0),
    .rdata1 (d_rd1)
  );

  // Centre weight, 1.0 - 2*(cx+cy+cz) in Q2.30, saturated.
  logic [33:0]              coef_sum;
  logic signed [35:0]       cw_full;
  logic signed [WORD_W-1:0] cw_r;

  assign coef_sum = 34'(coef_x_r) + 34'(coef_y_r) + 34'(coef_z_r);
  assign cw_full  = $signed(ONE_Q30) - $signed({1'b0, coef_sum, 1'b0});

  always_ff @(posedge clk) begin
    cw_r <= sat_word(37'(cw_full));
  end

  // Pipeline registers.
  logic  v1_r, v2_r, v3_r, v4_r, v5_r;
  ctrl_t c1_r, c2_r, c3_r, c4_r, c5_r, c1_full;
  logic signed [PROD_W-1:0] prod_r [8];
  logic signed [PROD_W:0]   pair_r [4];
  logic signed [WORD_W-1:0] new4_r, new5_r;
  logic [PEAK_W-1:0]        dabs_r;
  logic signed [WORD_W-1:0] cur_v, ym_v, yp_v, zm_v, zp_v;
  logic signed [WORD_W-1:0] sx_coef, sy_coef, sz_coef;
  logic signed [36:0]       total;
  logic signed [33:0]       diff, diff_abs;

  always_comb begin
    c1_full = c1_r;
    if (c1_r.odd) begin
      cur_v          = $signed(b_rd[0][0]);
      c1_full.centre = $signed(a_rd[0][0]);
      ym_v           = $signed(a_rd[0][1]);
      yp_v           = $signed(a_rd[1][0]);
      zm_v           = $signed(a_rd[1][1]);
      zp_v           = $signed(a_rd[2][0]);
    end else begin
      cur_v          = $signed(a_rd[0][0]);
      c1_full.centre = $signed(b_rd[0][0]);
      ym_v           = $signed(b_rd[0][1]);
      yp_v           = $signed(b_rd[1][0]);
      zm_v           = $signed(b_rd[1][1]);
      zp_v           = $signed(b_rd[2][0]);
    end
    sx_coef  = $signed({1'b0, coef_x_r});
    sy_coef  = $signed({1'b0, coef_y_r});
    sz_coef  = $signed({1'b0, coef_z_r});
    total    = 37'(pair_r[0]) + 37'(pair_r[1]) + 37'(pair_r[2]) + 37'(pair_r[3]);
    diff     = 34'(c4_r.centre) - 34'(new4_r);
    diff_abs = (diff < 0) ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r      <= c0;
    c2_r      <= c1_full;
    c3_r      <= c2_r;
    c4_r      <= c3_r;
    c5_r      <= c4_r;
    prod_r[0] <= mul_floor(cur_v, sx_coef);
    prod_r[1] <= mul_floor(c1_r.pot, sx_coef);
    prod_r[2] <= mul_floor(ym_v, sy_coef);
    prod_r[3] <= mul_floor(yp_v, sy_coef);
    prod_r[4] <= mul_floor(zm_v, sz_coef);
    prod_r[5] <= mul_floor(zp_v, sz_coef);
    prod_r[6] <= mul_floor($signed(d_rd0), coef_rho_r);
    prod_r[7] <= mul_floor(c1_full.centre, cw_r);
    pair_r[0] <= 35'(prod_r[0]) + 35'(prod_r[1]);
    pair_r[1] <= 35'(prod_r[2]) + 35'(prod_r[3]);
    pair_r[2] <= 35'(prod_r[4]) + 35'(prod_r[5]);
    pair_r[3] <= 35'(prod_r[7]) - 35'(prod_r[6]);
    new4_r    <= sat_word(total);
    new5_r    <= new4_r;
    dabs_r    <= (diff_abs[33:31] != '0) ? {PEAK_W{1'b1}} : diff_abs[PEAK_W-1:0];
  end

  // Peak of the change and result formation.
  logic [PEAK_W-1:0] peak_r, peak_base, peak_nxt;
  res_t              r1, r2;
  logic              n1, n2;

  always_comb begin
    peak_base = c5_r.clear ? '0 : peak_r;
    peak_nxt  = (c5_r.interior && dabs_r > peak_base) ? dabs_r : peak_base;
    n1        = c5_r.has_first;
    n2        = c5_r.has_second;

    r1.px      = c5_r.px;
    r1.py      = c5_r.py;
    r1.pz      = c5_r.pz;
    r1.written = c5_r.interior || c5_r.first_copy;
    r1.value   = c5_r.interior ? new5_r : (c5_r.first_copy ? c5_r.centre : '0);
    r1.peak    = peak_nxt;
    r1.last    = 1'b0;

    r2.px      = c5_r.qx;
    r2.py      = c5_r.py;
    r2.pz      = c5_r.pz;
    r2.written = c5_r.second_copy;
    r2.value   = c5_r.second_copy ? c5_r.pot : '0;
    r2.peak    = peak_nxt;
    r2.last    = c5_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (v5_r) begin
      peak_r <= peak_nxt;
    end
  end

  // Result queue. Every accepted item reserves two slots; slots it will not
  // fill are handed back when it leaves the pipeline.
  res_t              fifo_q [FIFO_DEPTH];
  logic [FIFO_W-1:0] rptr_r, wptr_r;
  logic [FIFO_W:0]   count_r, used_r;
  logic              pop;
  logic [FIFO_W:0]   n_wr, n_back;
  res_t              head;

  assign pop    = out_tvalid && out_tready;
  assign n_wr   = v5_r ? (FIFO_W+1)'(n1) + (FIFO_W+1)'(n2) : '0;
  assign n_back = v5_r ? (FIFO_W+1)'(2) - n_wr : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r  <= '0;
      wptr_r  <= '0;
      count_r <= '0;
      used_r  <= '0;
    end else begin
      rptr_r  <= rptr_r + FIFO_W'(pop);
      wptr_r  <= wptr_r + n_wr[FIFO_W-1:0];
      count_r <= count_r + n_wr - (FIFO_W+1)'(pop);
      used_r  <= used_r + (in_acc ? (FIFO_W+1)'(2) : '0) - (FIFO_W+1)'(pop) - n_back;
    end
  end

  always_ff @(posedge clk) begin
    if (v5_r) begin
      if (n1) begin
        fifo_q[wptr_r] <= r1;
      end
      if (n2) begin
        fifo_q[n1 ? wptr_r + FIFO_W'(1) : wptr_r] <= r2;
      end
    end
  end

  assign in_tready  = (used_r <= (FIFO_W+1)'(FIFO_DEPTH - 2));
  assign head       = fifo_q[rptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {7'd0, head.peak, head.value, head.pz, head.py, head.px};
  assign out_tuser  = head.written;
  assign out_tlast  = head.last;

  logic unused_rd;
  assign unused_rd = ^{a_rd[2][1], b_rd[2][1], d_rd1};

endmodule

### rtl/pjs_check.sv
// Port-level checker for the Jacobi sweep block, bound to its top level.
module pjs_check import pjs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   pready
);

`include "poisson_jacobi_sweep_7pt_assert.svh"

  // A border point that is not copied always carries a zero value.
  `PJS_ASSERT_SAME(unwritten_is_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[PEAK_LSB-1:VAL_LSB] == '0)

  // The configuration port never inserts wait states.
  `PJS_ASSERT_SAME(cfg_never_waits, clk, rst_n, 1'b1, pready)

  // Reset empties the result queue.
  `PJS_ASSERT_ALWAYS_NEXT(reset_empties, clk, !rst_n, !out_tvalid)

  // A stalled result stays offered and unchanged.
  `PJS_ASSERT_NEXT(stall_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind poisson_jacobi_sweep_7pt pjs_check u_pjs_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .pready     (pready)
);
